// ===== design/brpu_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilevel row pack/unpack package
// Shared types, register codes and constants for the pack/unpack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package brpu_pkg;

  // Defaults for the top-level size parameters
  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_MAX_ROWS    = 4096;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  // Register reset values
  localparam int RST_COLUMNS = 8;
  localparam int RST_ROWS    = 1;

  // Bit select table, first pixel lands in bit 7
  localparam logic [7:0] BIT_SEL [8] = '{8'd128, 8'd64, 8'd32, 8'd16,
                                         8'd8, 8'd4, 8'd2, 8'd1};
  localparam logic [7:0] PIXEL_ON  = 8'd255;
  localparam logic [7:0] PIXEL_OFF = 8'd0;

  // Work queue between front and back; depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One queued job: a packed byte to pass on, or a byte to expand to pixels
  typedef struct packed {
    logic       unpack;
    logic [7:0] data;
    logic [2:0] cnt_m1;     // pixels to emit minus one (zero for pack)
    logic       row_end;
    logic       frame_end;
  } q_entry_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ===== design/brpu_fifo.sv =====
// ----------------------------------------------------------------------------
// Work queue
// Small register FIFO that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module brpu_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire brpu_pkg::q_entry_t  push_entry,
  input  wire logic                pop,
  output brpu_pkg::q_entry_t       head,
  output brpu_pkg::q_status_t      status
);
  import brpu_pkg::*;

  q_entry_t           entries [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr;
  logic [FIFO_PW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

// ===== design/brpu_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts input words, packs pixels into bytes, tracks column and row
// position and queues one job per produced byte or per byte to unpack.
// ----------------------------------------------------------------------------
`default_nettype none

module brpu_front #(
  parameter int MAX_COLUMNS = brpu_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = brpu_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 direction,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]     num_cols,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]        num_rows,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [31:0]                   in_word,
  input  wire brpu_pkg::q_status_t                  q_status,
  output logic                                      push,
  output brpu_pkg::q_entry_t                        push_entry
);
  import brpu_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int NCW = $clog2(MAX_COLUMNS + 1);
  localparam int XW  = NCW + 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int YW  = NRW + 1;

  logic [7:0]    bit_accum;
  logic [2:0]    bit_count;
  logic [CW-1:0] column_index;
  logic [RW-1:0] row_index;

  logic [7:0]    accum_next;
  logic [XW-1:0] col_x;
  logic [XW-1:0] nc_x;
  logic [XW-1:0] remaining;
  logic          pack_row_done;
  logic          unp_row_done;
  logic          row_done;
  logic          frame_done;
  logic [2:0]    unp_cnt_m1;
  logic          accept;
  logic          emit;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign col_x = XW'(column_index);
  assign nc_x  = XW'(num_cols);

  // pack
  assign accum_next    = bit_accum | ((in_word != 32'sd0) ? BIT_SEL[bit_count] : 8'd0);
  assign pack_row_done = (col_x + XW'(1)) >= nc_x;

  // unpack: past the row length counts as one pixel left
  assign remaining    = (col_x < nc_x) ? (nc_x - col_x) : XW'(1);
  assign unp_row_done = remaining <= XW'(8);
  assign unp_cnt_m1   = unp_row_done ? 3'(remaining - XW'(1)) : 3'd7;

  assign row_done   = (direction == DIR_UNPACK) ? unp_row_done : pack_row_done;
  assign frame_done = row_done && ((YW'(row_index) + YW'(1)) >= YW'(num_rows));

  assign emit = (direction == DIR_UNPACK) || (bit_count == 3'd7) || pack_row_done;
  assign push = accept && emit;

  always_comb begin
    push_entry.unpack    = (direction == DIR_UNPACK);
    push_entry.data      = (direction == DIR_UNPACK) ? in_word[7:0] : accum_next;
    push_entry.cnt_m1    = (direction == DIR_UNPACK) ? unp_cnt_m1 : 3'd0;
    push_entry.row_end   = row_done;
    push_entry.frame_end = frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accum    <= '0;
      bit_count    <= '0;
      column_index <= '0;
      row_index    <= '0;
    end else if (accept) begin
      if (emit) begin
        bit_accum <= '0;
        bit_count <= '0;
      end else begin
        bit_accum <= accum_next;
        bit_count <= bit_count + 3'd1;
      end
      if (row_done) begin
        column_index <= '0;
        row_index    <= frame_done ? '0 : row_index + RW'(1);
      end else if (direction == DIR_UNPACK) begin
        column_index <= CW'(col_x + XW'(8));
      end else begin
        column_index <= column_index + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/brpu_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Drains queued jobs into the output register, one result per cycle while the receiver is ready;
// unpack jobs are expanded to pixels here.
// ----------------------------------------------------------------------------
`default_nettype none

module brpu_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire brpu_pkg::q_entry_t  head,
  input  wire brpu_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     last_of_item,
  output logic                     row_end,
  output logic                     frame_end
);
  import brpu_pkg::*;

  logic [2:0] pix_idx;
  logic       load;
  logic       last;
  logic [7:0] pixel;

  assign load = !q_status.empty && (!out_valid || out_ready);
  assign last = (pix_idx == head.cnt_m1);
  assign pop  = load && last;

  assign pixel = ((head.data & BIT_SEL[pix_idx]) != 8'd0) ? PIXEL_ON : PIXEL_OFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pix_idx   <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pix_idx   <= last ? 3'd0 : pix_idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.unpack ? pixel : head.data;
      last_of_item <= last;
      row_end      <= last && head.row_end;
      frame_end    <= last && head.frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== design/bilevel_row_pack_unpack_unit.sv =====
// ----------------------------------------------------------------------------
// Bilevel row pack/unpack unit
// Converts byte-per-pixel rows to MSB-first 1-bit rows padded to whole
// bytes, and back.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_word): pack mode takes one pixel per
//    transfer (nonzero sets the bit); unpack mode takes one packed byte in
//    in_word[7:0].
//  - Output channel (out_valid/out_ready): one result per transfer, with
//    last_of_item, row_end and frame_end flags.
//  - Config port (cfg_we/cfg_index/cfg_data): 0 direction, 1 columns,
//    2 rows. Write only while the unit is idle. Lengths of 0 act as 1 and
//    lengths above the maximum act as the maximum.
//  - Throughput: pack accepts one pixel per cycle while the queue has room.
//    Unpack delivers one pixel per cycle while the receiver is ready; a byte
//    yields 1 to 8 pixels (8 within a row, the pixels left at a row end),
//    counted out by the back end's pixel counter. With the queue empty, the
//    transfer writes the queue entry and the result then loads the output
//    register; further pixels of a byte follow one per cycle while ready.
//  - Reset: direction pack, columns 8, rows 1, counters and queue cleared.
//  - Stall: the output register holds; the 4-entry queue fills, then
//    in_ready drops until the receiver takes results again.
// ----------------------------------------------------------------------------
`default_nettype none

module bilevel_row_pack_unpack_unit #(
  parameter int MAX_COLUMNS = brpu_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = brpu_pkg::DEF_MAX_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [brpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brpu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [31:0]              in_word,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 last_of_item,
  output logic                                 row_end,
  output logic                                 frame_end
);
  import brpu_pkg::*;

  localparam int NCW = $clog2(MAX_COLUMNS + 1);
  localparam int NRW = $clog2(MAX_ROWS + 1);

  // Config registers; lengths are stored already clamped
  logic           direction;
  logic [NCW-1:0] num_cols;
  logic [NRW-1:0] num_rows;

  q_entry_t  push_entry;
  q_entry_t  head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_PACK;
      num_cols  <= NCW'(RST_COLUMNS);
      num_rows  <= NRW'(RST_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_COLUMNS: begin
          if (cfg_data == '0) begin
            num_cols <= NCW'(1);
          end else if (32'(cfg_data) > 32'(MAX_COLUMNS)) begin
            num_cols <= NCW'(MAX_COLUMNS);
          end else begin
            num_cols <= NCW'(cfg_data);
          end
        end
        CFG_ROWS: begin
          if (cfg_data == '0) begin
            num_rows <= NRW'(1);
          end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
            num_rows <= NRW'(MAX_ROWS);
          end else begin
            num_rows <= NRW'(cfg_data);
          end
        end
        default: ;  // unused index, write dropped
      endcase
    end
  end

  brpu_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .num_cols  (num_cols),
    .num_rows  (num_rows),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .q_status  (q_status),
    .push      (push),
    .push_entry(push_entry)
  );

  brpu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  brpu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_item(last_of_item),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

  // Checks
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_frame_implies_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (row_end && last_of_item))
    else $error("frame end without row end on final result");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("work queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty work queue");

endmodule

`default_nettype wire

// ===== dv/brpu_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilevel row pack/unpack stream checker
// Watches the config port and both channels, keeps its own copy of the
// packer state, and compares each output transfer with the oldest predicted
// result.
// ----------------------------------------------------------------------------

module brpu_stream_checker #(
  parameter int MAX_COLUMNS = brpu_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = brpu_pkg::DEF_MAX_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [brpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brpu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic signed [31:0]              in_word,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [7:0]                      out_byte,
  input  wire logic                            last_of_item,
  input  wire logic                            row_end,
  input  wire logic                            frame_end,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   result_count
);
  import brpu_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       row_end;
    logic       frame_end;
  } byte_result_t;

  byte_result_t expected_bytes[$];

  // shadow registers and state
  logic                  dir_q;
  logic [CFG_DATA_W-1:0] cols_q;
  logic [CFG_DATA_W-1:0] rows_q;
  logic [7:0]            acc_q;
  logic [2:0]            fill_q;
  logic [11:0]           col_q;
  logic [11:0]           row_q;

  function automatic int unsigned eff_len(input logic [CFG_DATA_W-1:0] v,
                                          input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // row is done: rewind the column, step the row, flag frame end
  function automatic logic close_row();
    col_q = '0;
    if (32'(row_q) + 1 >= eff_len(rows_q, MAX_ROWS)) begin
      row_q = '0;
      return 1'b1;
    end
    row_q++;
    return 1'b0;
  endfunction

  task automatic pack_or_expand(input logic [31:0] w);
    int unsigned  nc;
    int unsigned  left;
    int unsigned  n;
    logic         done;
    logic         fend;
    byte_result_t r;
    nc = eff_len(cols_q, MAX_COLUMNS);
    if (dir_q == DIR_PACK) begin
      if (w != 0) acc_q |= 8'h80 >> fill_q;
      done = (32'(col_q) + 1 >= nc);
      col_q++;
      if (fill_q == 3'd7 || done) begin
        fend        = done ? close_row() : 1'b0;
        r.value     = acc_q;
        r.last      = 1'b1;
        r.row_end   = done;
        r.frame_end = fend;
        expected_bytes.push_back(r);
        acc_q  = '0;
        fill_q = '0;
      end else begin
        fill_q++;
      end
    end else begin
      acc_q  = '0;
      fill_q = '0;
      left   = (32'(col_q) < nc) ? nc - 32'(col_q) : 1;
      n      = (left < 8) ? left : 8;
      done   = (left <= 8);
      col_q  = col_q + 12'(n);
      fend   = done ? close_row() : 1'b0;
      for (int k = 0; k < n; k++) begin
        r.value     = w[7-k] ? PIXEL_ON : PIXEL_OFF;
        r.last      = (k == n - 1);
        r.row_end   = r.last && done;
        r.frame_end = r.last && done && fend;
        expected_bytes.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 30) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    byte_result_t exp_r;
    if (rst) begin
      dir_q  = DIR_PACK;
      cols_q = CFG_DATA_W'(RST_COLUMNS);
      rows_q = CFG_DATA_W'(RST_ROWS);
      acc_q  = '0;
      fill_q = '0;
      col_q  = '0;
      row_q  = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION: dir_q  = cfg_data[0];
          CFG_COLUMNS:   cols_q = cfg_data;
          CFG_ROWS:      rows_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) pack_or_expand(in_word);
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected result %02h", out_byte));
        end else begin
          exp_r = expected_bytes.pop_front();
          result_count++;
          if (out_byte !== exp_r.value)
            report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                      result_count, out_byte, exp_r.value));
          if (last_of_item !== exp_r.last)
            report_mismatch($sformatf("result %0d last_of_item %b, want %b",
                                      result_count, last_of_item, exp_r.last));
          if (row_end !== exp_r.row_end)
            report_mismatch($sformatf("result %0d row_end %b, want %b",
                                      result_count, row_end, exp_r.row_end));
          if (frame_end !== exp_r.frame_end)
            report_mismatch($sformatf("result %0d frame_end %b, want %b",
                                      result_count, frame_end, exp_r.frame_end));
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== dv/tb_bilevel_row_pack_unpack_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilevel row pack/unpack unit testbench
// Directed pack and unpack frames first (field extremes, row padding, length
// clamping, register changes in the middle of a frame), then random register
// settings with whole frames of random pixels or bytes, plus cut-off frames.
// The sender runs in bursts and the receiver stalls on its own schedule; the
// stream checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------

module tb_bilevel_row_pack_unpack_unit;
  import brpu_pkg::*;

  localparam int RANDOM_ITEMS = 120;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DIRECTION;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic signed [31:0]    in_word   = '0;
  logic                  out_ready = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       row_end;
  logic       frame_end;

  int fails;
  int pending;
  int results_seen;

  // stimulus bookkeeping
  int          items_sent = 0;
  int          settings   = 0;
  int unsigned burst_left = 0;

  // receiver stall schedule
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned tick       = 0;

  always #10 clk = ~clk;

  bilevel_row_pack_unpack_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

  brpu_stream_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .fail_count   (fails),
    .pending      (pending),
    .result_count (results_seen)
  );

  // Receiver: when the current stall style runs out, pick a new one. Style 0
  // never stalls, 1 stalls lightly, 2 stalls heavily (fills the queue and
  // pushes back on in_ready), 3 follows a fixed repeating on/off pattern.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    tick++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((tick % 11) < 6);
    endcase
  end

  // One input transfer. Called at a falling edge; valid is held with the
  // word until the transfer, then either stays high for the next word of the
  // burst or drops for a random gap. Burst lengths are mostly short,
  // sometimes long enough to run a stretch with no gaps at all.
  task automatic send_word(input logic [31:0] w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Drain: stop sending, wait for every predicted result, then let the
  // two-stage pipe settle in case a partial pack byte is the last thing in
  // flight (it produces nothing to wait for).
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // Program all three registers back to back; only called while drained.
  // The direction write carries random upper bits, which the unit ignores.
  task automatic program_unit(input logic dir, input logic [CFG_DATA_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] nrows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_data  <= {12'($urandom_range(0, 4095)), dir};
    @(negedge clk);
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= nrows;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Pack pixels: half zero, the rest small, full-scale or any 32-bit value.
  function automatic logic [31:0] random_pixel();
    case ($urandom_range(0, 5))
      0, 1, 2: return 32'd0;
      3:       return 32'd255;
      4:       return $urandom_range(1, 255);
      default: return $urandom();
    endcase
  endfunction

  // One random setting. Mostly short rows and few rows so whole frames fit,
  // with the length extremes (0, 1, max, above max) mixed in. A whole frame
  // is sent most of the time; otherwise a cut-off run that leaves the unit
  // mid-row / mid-frame for the next setting to pick up.
  task automatic random_setting();
    logic                  dir;
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] nrows;
    int unsigned           nc;
    int unsigned           nr;
    int unsigned           frame_len;
    int unsigned           count;
    dir = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       cols = '0;
      1:       cols = 13'd4096;
      2:       cols = '1;
      3:       cols = 13'd1;
      default: cols = 13'($urandom_range(2, 24));
    endcase
    case ($urandom_range(0, 7))
      0:       nrows = '0;
      1:       nrows = '1;
      2:       nrows = 13'd4096;
      default: nrows = 13'($urandom_range(1, 4));
    endcase
    program_unit(dir, cols, nrows);
    nc = (cols == 0) ? 1 : ((cols > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols);
    nr = (nrows == 0) ? 1 : ((nrows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : nrows);
    frame_len = ((dir == DIR_UNPACK) ? (nc + 7) / 8 : nc) * nr;
    if (frame_len <= 48 && $urandom_range(0, 5) != 0) count = frame_len;
    else count = $urandom_range(1, 30);
    for (int i = 0; i < count; i++)
      send_word((dir == DIR_UNPACK) ? $urandom() : random_pixel());
    drain();
  endtask

  initial begin
    int directed_items;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings (pack, 8 columns, 1 row): one full byte from pixel
    // extremes -> 0x7B with row and frame end.
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'd0);
    send_word(32'h0000_0100);
    send_word(32'd1);
    drain();

    // 3-pixel rows, 2 rows: each row flushes a padded byte.
    program_unit(DIR_PACK, 13'd3, 13'd2);
    send_word(32'd1);
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd0);
    send_word(32'd0);
    send_word(32'd5);
    drain();

    // Unpack an 11-pixel row: 8 pixels, then only the 3 left; upper bits
    // of the word must be ignored.
    program_unit(DIR_UNPACK, 13'd11, 13'd1);
    send_word(32'hFFFF_FF5A);
    send_word(32'h0000_01E0);
    drain();

    // Zero lengths act as one: a byte yields a single pixel.
    program_unit(DIR_UNPACK, 13'd0, 13'd0);
    send_word(32'h0000_00FF);
    drain();

    // Oversized row, partial pack byte left in the accumulator.
    program_unit(DIR_PACK, 13'h1FFF, 13'h1FFF);
    send_word(32'd1);
    send_word(32'd0);
    send_word(32'd7);
    drain();

    // Switch to unpack mid-row: accumulator is dropped, 9 columns left so a
    // full 8 pixels come out without a row end.
    program_unit(DIR_UNPACK, 13'd12, 13'd1);
    send_word(32'h0000_00C3);
    drain();

    // Shrink the row below the current column: the next single pixel ends it.
    program_unit(DIR_UNPACK, 13'd5, 13'd1);
    send_word(32'h0000_0080);
    drain();

    // Back to pack from a clean accumulator: 2-pixel row -> 0x40.
    program_unit(DIR_PACK, 13'd2, 13'd1);
    send_word(32'd0);
    send_word(32'hDEAD_BEEF);
    drain();

    directed_items = items_sent;
    while (items_sent < directed_items + RANDOM_ITEMS) random_setting();
    drain();
    repeat (8) @(negedge clk);

    $display("Run covered %0d input transfers over %0d register settings,",
             items_sent, settings);
    $display("with %0d results checked against the prediction.", results_seen);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout: run did not complete");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/brpu_pkg.sv
design/brpu_fifo.sv
design/brpu_front.sv
design/brpu_back.sv
design/bilevel_row_pack_unpack_unit.sv
dv/brpu_stream_checker.sv
dv/tb_bilevel_row_pack_unpack_unit.sv
